// File: src/ipr_pkg.sv
// Shared types, codes and count helpers for the IP range/prefix encoder.
package ipr_pkg;

    localparam int ADDR_W    = 128;
    localparam int V4_W      = 32;
    localparam int WORD_W    = 64;
    localparam int LEN_W     = 8;

    localparam logic [1:0] FAM_IPV4 = 2'd0;
    localparam logic [1:0] FAM_IPV6 = 2'd1;

    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(ADDR_W);

    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_BAD_FAMILY     = 2'd1,
        ST_LOW_ABOVE_HIGH = 2'd2
    } t_status;

    typedef struct packed {
        t_status          status;
        logic             is_range;
        logic [LEN_W-1:0] prefix_bits;
        logic [LEN_W-1:0] min_bits;
        logic [LEN_W-1:0] max_bits;
    } t_result;

    // Leading zero count of a 128-bit word, 128 when the word is zero.
    // Seven halving steps, each a zero test and a shift.
    function automatic logic [LEN_W-1:0] lzc128(input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] t;
        logic [LEN_W-1:0]  n;
        t = v;
        n = '0;
        if (t[127:64] == '0) begin
            n[6] = 1'b1;
            t    = {t[63:0], 64'd0};
        end
        if (t[127:96] == '0) begin
            n[5] = 1'b1;
            t    = {t[95:0], 32'd0};
        end
        if (t[127:112] == '0) begin
            n[4] = 1'b1;
            t    = {t[111:0], 16'd0};
        end
        if (t[127:120] == '0) begin
            n[3] = 1'b1;
            t    = {t[119:0], 8'd0};
        end
        if (t[127:124] == '0) begin
            n[2] = 1'b1;
            t    = {t[123:0], 4'd0};
        end
        if (t[127:126] == '0) begin
            n[1] = 1'b1;
            t    = {t[125:0], 2'd0};
        end
        if (!t[127]) begin
            n[0] = 1'b1;
        end
        if (v == '0) begin
            n = FULL_LEN;
        end
        return n;
    endfunction

    function automatic logic [ADDR_W-1:0] rev128(input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] r;
        for (int i = 0; i < ADDR_W; i++) begin
            r[i] = v[ADDR_W-1-i];
        end
        return r;
    endfunction

endpackage

// File: src/ipr_encode.sv
// Combinational prefix/range decision for one registered address pair.
module ipr_encode (
    input  logic [1:0]                   i_family,
    input  logic [ipr_pkg::WORD_W-1:0]   i_low_upper,
    input  logic [ipr_pkg::WORD_W-1:0]   i_low_lower,
    input  logic [ipr_pkg::WORD_W-1:0]   i_high_upper,
    input  logic [ipr_pkg::WORD_W-1:0]   i_high_lower,
    output ipr_pkg::t_result             o_result
);

    localparam int PAD_W = ipr_pkg::ADDR_W - ipr_pkg::V4_W;

    logic                        fam_ok;
    logic [ipr_pkg::ADDR_W-1:0]  lo;
    logic [ipr_pkg::ADDR_W-1:0]  hi;
    logic [ipr_pkg::ADDR_W-1:0]  diff;
    logic [ipr_pkg::ADDR_W-1:0]  diff_inc;
    logic                        pfx_exact;
    logic                        above;
    logic [ipr_pkg::LEN_W-1:0]   common_len;
    logic [ipr_pkg::LEN_W-1:0]   lo_tz;
    logic [ipr_pkg::LEN_W-1:0]   hi_to;

    // An IPv4 pair is padded with zeros under low and ones under high. The
    // padding never changes the order, never adds a trailing bit to either
    // end, and makes a full 32-bit match read as a prefix of 32.
    always_comb begin
        fam_ok = 1'b1;
        lo     = {i_low_upper, i_low_lower};
        hi     = {i_high_upper, i_high_lower};
        unique case (i_family)
            ipr_pkg::FAM_IPV4: begin
                lo = {i_low_upper[ipr_pkg::WORD_W-1 -: ipr_pkg::V4_W], {PAD_W{1'b0}}};
                hi = {i_high_upper[ipr_pkg::WORD_W-1 -: ipr_pkg::V4_W], {PAD_W{1'b1}}};
            end
            ipr_pkg::FAM_IPV6: begin
                fam_ok = 1'b1;
            end
            default: begin
                fam_ok = 1'b0;
            end
        endcase
    end

    // Once low is not above high, the pair is a prefix when the bits past
    // the common part differ everywhere with low holding zeros there.
    assign diff       = lo ^ hi;
    assign diff_inc   = diff + {{(ipr_pkg::ADDR_W-1){1'b0}}, 1'b1};
    assign pfx_exact  = ((diff & diff_inc) == '0) && ((lo & diff) == '0);
    assign above      = lo > hi;
    assign common_len = ipr_pkg::lzc128(diff);
    assign lo_tz      = ipr_pkg::lzc128(ipr_pkg::rev128(lo));
    assign hi_to      = ipr_pkg::lzc128(ipr_pkg::rev128(~hi));

    always_comb begin
        o_result = '0;
        if (!fam_ok) begin
            o_result.status = ipr_pkg::ST_BAD_FAMILY;
        end else if (above) begin
            o_result.status = ipr_pkg::ST_LOW_ABOVE_HIGH;
        end else if (pfx_exact) begin
            o_result.status      = ipr_pkg::ST_OK;
            o_result.prefix_bits = common_len;
        end else begin
            o_result.status   = ipr_pkg::ST_OK;
            o_result.is_range = 1'b1;
            o_result.min_bits = (lo == '0) ? '0 : ipr_pkg::FULL_LEN - lo_tz;
            o_result.max_bits = (~hi == '0) ? '0 : ipr_pkg::FULL_LEN - hi_to;
        end
    end

endmodule

// File: src/ip_range_prefix_encoder_top.sv
// Top level of the IP range/prefix encoder: input register, encoder, result register.
//
// The block takes one address pair a cycle and never raises busy. Each result
// appears on the o_ ports with o_valid after the start beat that carried the pair
// has passed the input register and then the encoder's 128-bit compare and
// leading/trailing bit counts into the result register. The
// result stays for exactly one cycle and cannot be held back, so the receiver
// must take every beat in the cycle it is shown.
module ip_range_prefix_encoder_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_family,
    input  logic [ipr_pkg::WORD_W-1:0]   i_low_upper,
    input  logic [ipr_pkg::WORD_W-1:0]   i_low_lower,
    input  logic [ipr_pkg::WORD_W-1:0]   i_high_upper,
    input  logic [ipr_pkg::WORD_W-1:0]   i_high_lower,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic                         o_is_range,
    output logic [ipr_pkg::LEN_W-1:0]    o_prefix_bits,
    output logic [ipr_pkg::LEN_W-1:0]    o_min_bits,
    output logic [ipr_pkg::LEN_W-1:0]    o_max_bits
);

    logic                        accept;
    logic                        r_in_vld;
    logic [1:0]                  r_family;
    logic [ipr_pkg::WORD_W-1:0]  r_low_upper;
    logic [ipr_pkg::WORD_W-1:0]  r_low_lower;
    logic [ipr_pkg::WORD_W-1:0]  r_high_upper;
    logic [ipr_pkg::WORD_W-1:0]  r_high_lower;
    ipr_pkg::t_result            n_result;
    ipr_pkg::t_result            r_result;
    logic                        r_out_vld;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= accept;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_family     <= i_family;
            r_low_upper  <= i_low_upper;
            r_low_lower  <= i_low_lower;
            r_high_upper <= i_high_upper;
            r_high_lower <= i_high_lower;
        end
        if (r_in_vld) begin
            r_result <= n_result;
        end
    end

    ipr_encode u_encode (
        .i_family     (r_family),
        .i_low_upper  (r_low_upper),
        .i_low_lower  (r_low_lower),
        .i_high_upper (r_high_upper),
        .i_high_lower (r_high_lower),
        .o_result     (n_result)
    );

    assign o_valid       = r_out_vld;
    assign o_status      = r_result.status;
    assign o_is_range    = r_result.is_range;
    assign o_prefix_bits = r_result.prefix_bits;
    assign o_min_bits    = r_result.min_bits;
    assign o_max_bits    = r_result.max_bits;

endmodule

// File: src/ipr_checker.sv
// Port-level checks for the IP range/prefix encoder, bound to the top level.
module ipr_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [1:0]                   i_family,
    input logic                         o_valid,
    input logic [1:0]                   o_status,
    input logic                         o_is_range,
    input logic [ipr_pkg::LEN_W-1:0]    o_prefix_bits,
    input logic [ipr_pkg::LEN_W-1:0]    o_min_bits,
    input logic [ipr_pkg::LEN_W-1:0]    o_max_bits
);

    // Every accepted beat yields exactly one result, and no result comes without one.
    a_one_result: assert property (@(posedge i_clk)
        i_rst_n && $past(i_rst_n) && $past(i_rst_n, 2)
            |-> (o_valid == $past(start && !busy, 2)))
        else $error("result strobe does not match accepted beats");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ipr_pkg::ST_OK)
            |-> (!o_is_range && o_prefix_bits == '0 && o_min_bits == '0
                 && o_max_bits == '0))
        else $error("error result carries nonzero fields");

    a_family: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_status == ipr_pkg::ST_BAD_FAMILY)
                     == ($past(i_family, 2) != ipr_pkg::FAM_IPV4
                         && $past(i_family, 2) != ipr_pkg::FAM_IPV6)))
        else $error("family check disagrees with accepted family");

    a_prefix_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ipr_pkg::ST_OK) && !o_is_range
            |-> (o_min_bits == '0 && o_max_bits == '0
                 && o_prefix_bits <= ipr_pkg::FULL_LEN))
        else $error("prefix result has bad lengths");

    a_range_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_range
            |-> (o_status == ipr_pkg::ST_OK && o_prefix_bits == '0
                 && o_min_bits <= ipr_pkg::FULL_LEN
                 && o_max_bits <= ipr_pkg::FULL_LEN))
        else $error("range result has bad lengths");

endmodule

bind ip_range_prefix_encoder_top ipr_checker u_ipr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_family      (i_family),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_is_range    (o_is_range),
    .o_prefix_bits (o_prefix_bits),
    .o_min_bits    (o_min_bits),
    .o_max_bits    (o_max_bits)
);

// File: tb/ip_range_prefix_encoder_top_tb.sv
// Self-checking testbench for the IP range/prefix encoder top level.
module ip_range_prefix_encoder_top_tb;

    localparam logic [1:0]                 FAM_BAD_LO = 2'd2;
    localparam logic [1:0]                 FAM_BAD_HI = 2'd3;
    localparam logic [ipr_pkg::ADDR_W-1:0] ONES       = '1;
    localparam logic [ipr_pkg::ADDR_W-1:0] ONE_MSB    = {1'b1, 127'd0};
    localparam logic [ipr_pkg::WORD_W-1:0] W_ZERO     = '0;
    localparam logic [ipr_pkg::WORD_W-1:0] W_ONES     = '1;
    localparam int                         N_DIRECTED = 21;
    localparam int                         N_RANDOM   = 1800;

    localparam ipr_pkg::t_result RES_BAD_FAMILY =
        '{ipr_pkg::ST_BAD_FAMILY, 1'b0, 8'd0, 8'd0, 8'd0};
    localparam ipr_pkg::t_result RES_LOW_ABOVE  =
        '{ipr_pkg::ST_LOW_ABOVE_HIGH, 1'b0, 8'd0, 8'd0, 8'd0};
    localparam ipr_pkg::t_result RES_PREFIX_0   = '{ipr_pkg::ST_OK, 1'b0, 8'd0, 8'd0, 8'd0};
    localparam ipr_pkg::t_result RES_PREFIX_32  = '{ipr_pkg::ST_OK, 1'b0, 8'd32, 8'd0, 8'd0};
    localparam ipr_pkg::t_result RES_PREFIX_128 = '{ipr_pkg::ST_OK, 1'b0, 8'd128, 8'd0, 8'd0};
    localparam ipr_pkg::t_result RES_UNTYPED    = '{ipr_pkg::ST_OK, 1'b0, 8'd0, 8'd0, 8'd0};

    typedef struct {
        logic [1:0]                 fam;
        logic [ipr_pkg::WORD_W-1:0] lu;
        logic [ipr_pkg::WORD_W-1:0] ll;
        logic [ipr_pkg::WORD_W-1:0] hu;
        logic [ipr_pkg::WORD_W-1:0] hl;
        bit                         typed;
        ipr_pkg::t_result           res;
    } t_dir_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [1:0]                 i_family;
    logic [ipr_pkg::WORD_W-1:0] i_low_upper;
    logic [ipr_pkg::WORD_W-1:0] i_low_lower;
    logic [ipr_pkg::WORD_W-1:0] i_high_upper;
    logic [ipr_pkg::WORD_W-1:0] i_high_lower;
    logic                       o_valid;
    logic [1:0]                 o_status;
    logic                       o_is_range;
    logic [ipr_pkg::LEN_W-1:0]  o_prefix_bits;
    logic [ipr_pkg::LEN_W-1:0]  o_min_bits;
    logic [ipr_pkg::LEN_W-1:0]  o_max_bits;

    // Typed result that rides along with the beat on the input ports.
    logic                       cur_typed;
    ipr_pkg::t_result           cur_typed_res;

    ipr_pkg::t_result           pending_encodings[$];
    int                         mismatch_count;
    bit                         steady;
    t_dir_row                   dir_rows [0:N_DIRECTED-1];

    ip_range_prefix_encoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_family      (i_family),
        .i_low_upper   (i_low_upper),
        .i_low_lower   (i_low_lower),
        .i_high_upper  (i_high_upper),
        .i_high_lower  (i_high_lower),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_is_range    (o_is_range),
        .o_prefix_bits (o_prefix_bits),
        .o_min_bits    (o_min_bits),
        .o_max_bits    (o_max_bits)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic ipr_pkg::t_result choose_encoding(
            input logic [1:0] fam,
            input logic [ipr_pkg::ADDR_W-1:0] lo,
            input logic [ipr_pkg::ADDR_W-1:0] hi);
        ipr_pkg::t_result r;
        int               w;
        int               shared;
        bit               exact;
        r = '0;
        r.status = ipr_pkg::ST_OK;
        if (fam == ipr_pkg::FAM_IPV4) begin
            w = ipr_pkg::V4_W;
        end else if (fam == ipr_pkg::FAM_IPV6) begin
            w = ipr_pkg::ADDR_W;
        end else begin
            r.status = ipr_pkg::ST_BAD_FAMILY;
            return r;
        end
        shared = 0;
        while (shared < w
               && lo[ipr_pkg::ADDR_W-1-shared] == hi[ipr_pkg::ADDR_W-1-shared]) begin
            shared++;
        end
        // The first differing bit decides the order of the two addresses.
        if (shared < w && lo[ipr_pkg::ADDR_W-1-shared]) begin
            r.status = ipr_pkg::ST_LOW_ABOVE_HIGH;
            return r;
        end
        exact = 1'b1;
        for (int i = shared; i < w; i++) begin
            if (lo[ipr_pkg::ADDR_W-1-i] || !hi[ipr_pkg::ADDR_W-1-i]) begin
                exact = 1'b0;
            end
        end
        if (exact) begin
            r.prefix_bits = ipr_pkg::LEN_W'(shared);
            return r;
        end
        r.is_range = 1'b1;
        for (int i = 0; i < w; i++) begin
            if (lo[ipr_pkg::ADDR_W-1-i]) begin
                r.min_bits = ipr_pkg::LEN_W'(i + 1);
            end
            if (!hi[ipr_pkg::ADDR_W-1-i]) begin
                r.max_bits = ipr_pkg::LEN_W'(i + 1);
            end
        end
        return r;
    endfunction

    function automatic logic [ipr_pkg::ADDR_W-1:0] rand_addr();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Mostly ordered pairs: exact prefixes, prefixes with one bit disturbed,
    // ranges with varied trailing runs, equal pairs; the rest is raw noise.
    task automatic make_random_pair(output logic [1:0] fam,
                                    output logic [ipr_pkg::ADDR_W-1:0] lo,
                                    output logic [ipr_pkg::ADDR_W-1:0] hi);
        int                         kind;
        int                         w;
        int                         plen;
        int                         k1;
        int                         k2;
        int                         p;
        logic [ipr_pkg::ADDR_W-1:0] base;
        logic [ipr_pkg::ADDR_W-1:0] topw;
        logic [ipr_pkg::ADDR_W-1:0] hostm;
        logic [ipr_pkg::ADDR_W-1:0] bitp;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 8) begin
            fam = ($urandom_range(0, 1) != 0) ? FAM_BAD_HI : FAM_BAD_LO;
        end else begin
            fam = ($urandom_range(0, 1) != 0) ? ipr_pkg::FAM_IPV6 : ipr_pkg::FAM_IPV4;
        end
        w = (fam == ipr_pkg::FAM_IPV4) ? ipr_pkg::V4_W : ipr_pkg::ADDR_W;
        topw = ~(ONES >> w);
        base = rand_addr();
        plen = $urandom_range(0, w);
        hostm = topw & (ONES >> plen);
        if (kind < 50) begin
            lo = base & ~hostm;
            hi = base | hostm;
            if (kind >= 35 && plen < w) begin
                p = $urandom_range(plen, w - 1);
                bitp = ONE_MSB >> p;
                if ($urandom_range(0, 1) != 0) begin
                    lo = lo | bitp;
                end else begin
                    hi = hi & ~bitp;
                end
            end
        end else if (kind < 75) begin
            plen = $urandom_range(0, w - 1);
            k1 = $urandom_range(plen + 1, w);
            k2 = $urandom_range(plen + 1, w);
            hostm = topw & (ONES >> plen);
            bitp = ONE_MSB >> plen;
            lo = ((base & ~hostm) | (rand_addr() & hostm & ~(ONES >> k1))) & ~bitp;
            hi = (base & ~hostm) | ((rand_addr() | (ONES >> k2)) & hostm) | bitp;
        end else if (kind < 85) begin
            lo = base;
            hi = base;
        end else begin
            lo = rand_addr();
            hi = rand_addr();
        end
        // Bits outside the address width get their own random content.
        lo = (lo & topw) | (rand_addr() & ~topw);
        hi = (hi & topw) | (rand_addr() & ~topw);
    endtask

    task automatic send_pair(input logic [1:0] fam,
                             input logic [ipr_pkg::ADDR_W-1:0] lo,
                             input logic [ipr_pkg::ADDR_W-1:0] hi, input bit typed,
                             input ipr_pkg::t_result typed_res);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_family      <= fam;
        i_low_upper   <= lo[ipr_pkg::ADDR_W-1:ipr_pkg::WORD_W];
        i_low_lower   <= lo[ipr_pkg::WORD_W-1:0];
        i_high_upper  <= hi[ipr_pkg::ADDR_W-1:ipr_pkg::WORD_W];
        i_high_lower  <= hi[ipr_pkg::WORD_W-1:0];
        cur_typed     <= typed;
        cur_typed_res <= typed_res;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        ipr_pkg::t_result want;
        if (o_valid) begin
            if (pending_encodings.size() == 0) begin
                report_mismatch("result beat with no encoding pending");
            end else begin
                want = pending_encodings.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_status, want.status));
                if (o_is_range !== want.is_range)
                    report_mismatch($sformatf("is_range got %0d want %0d",
                                              o_is_range, want.is_range));
                if (o_prefix_bits !== want.prefix_bits)
                    report_mismatch($sformatf("prefix_bits got %0d want %0d",
                                              o_prefix_bits, want.prefix_bits));
                if (o_min_bits !== want.min_bits)
                    report_mismatch($sformatf("min_bits got %0d want %0d",
                                              o_min_bits, want.min_bits));
                if (o_max_bits !== want.max_bits)
                    report_mismatch($sformatf("max_bits got %0d want %0d",
                                              o_max_bits, want.max_bits));
            end
        end
        if (i_rst_n && start && !busy) begin
            if (cur_typed) begin
                pending_encodings.push_back(cur_typed_res);
            end else begin
                pending_encodings.push_back(choose_encoding(i_family,
                    {i_low_upper, i_low_lower}, {i_high_upper, i_high_lower}));
            end
        end
    end

    initial begin
        #2000000;
        $display("ip_range_prefix_encoder_top verification failed");
        $finish;
    end

    initial begin : stimulus
        logic [1:0]                 fam;
        logic [ipr_pkg::ADDR_W-1:0] lo;
        logic [ipr_pkg::ADDR_W-1:0] hi;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_family       = ipr_pkg::FAM_IPV4;
        i_low_upper    = '0;
        i_low_lower    = '0;
        i_high_upper   = '0;
        i_high_lower   = '0;
        cur_typed      = 1'b0;
        cur_typed_res  = RES_UNTYPED;
        mismatch_count = 0;
        steady         = 1'b0;

        dir_rows = '{
            '{FAM_BAD_LO, W_ZERO, W_ZERO, W_ZERO, W_ZERO, 1'b1, RES_BAD_FAMILY},
            '{FAM_BAD_HI, W_ONES, W_ONES, W_ONES, W_ONES, 1'b1, RES_BAD_FAMILY},
            '{ipr_pkg::FAM_IPV6, W_ZERO, W_ZERO, W_ONES, W_ONES, 1'b1, RES_PREFIX_0},
            '{ipr_pkg::FAM_IPV6, W_ONES, W_ONES, W_ONES, W_ONES, 1'b1, RES_PREFIX_128},
            '{ipr_pkg::FAM_IPV6, W_ZERO, W_ZERO, W_ZERO, W_ZERO, 1'b1, RES_PREFIX_128},
            '{ipr_pkg::FAM_IPV4, 64'h0000_0000_FFFF_FFFF, W_ONES,
              64'hFFFF_FFFF_0000_0000, W_ZERO, 1'b1, RES_PREFIX_0},
            '{ipr_pkg::FAM_IPV4, 64'hC0A8_0001_FFFF_FFFF, W_ONES,
              64'hC0A8_0001_0000_0000, W_ZERO, 1'b1, RES_PREFIX_32},
            '{ipr_pkg::FAM_IPV6, W_ONES, W_ONES, W_ZERO, W_ZERO, 1'b1, RES_LOW_ABOVE},
            '{ipr_pkg::FAM_IPV4, 64'h0A00_0001_0000_0000, W_ZERO,
              64'h0A00_0000_FFFF_FFFF, W_ONES, 1'b1, RES_LOW_ABOVE},
            '{ipr_pkg::FAM_IPV6, 64'h1234, 64'h1, 64'h1234, 64'h0, 1'b1, RES_LOW_ABOVE},
            '{ipr_pkg::FAM_IPV4, 64'h0A00_0001_0000_0000, W_ZERO,
              64'h0A00_00FE_0000_0000, W_ZERO, 1'b0, RES_UNTYPED},
            '{ipr_pkg::FAM_IPV6, W_ZERO, W_ZERO, 64'h7FFF_FFFF_FFFF_FFFF,
              64'hFFFF_FFFF_FFFF_FFFE, 1'b0, RES_UNTYPED},
            '{ipr_pkg::FAM_IPV6, W_ZERO, 64'h1, W_ONES, W_ONES, 1'b0, RES_UNTYPED},
            '{ipr_pkg::FAM_IPV6, 64'h2001_0DB8_0000_0001, W_ZERO,
              64'h2001_0DB8_0000_0001, W_ONES, 1'b0, RES_UNTYPED},
            '{ipr_pkg::FAM_IPV4, 64'h0A01_0200_0000_0000, W_ZERO,
              64'h0A01_02FF_0000_0000, W_ZERO, 1'b0, RES_UNTYPED},
            '{ipr_pkg::FAM_IPV6, 64'h8000_0000_0000_0000, W_ZERO, W_ONES, W_ONES,
              1'b0, RES_UNTYPED},
            '{ipr_pkg::FAM_IPV6, W_ZERO, W_ONES, 64'h1, W_ZERO, 1'b0, RES_UNTYPED},
            '{ipr_pkg::FAM_IPV6, 64'hFE80_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFE,
              64'hFE80_0000_0000_0000, W_ONES, 1'b0, RES_UNTYPED},
            '{ipr_pkg::FAM_IPV4, W_ZERO, W_ZERO, 64'h7FFF_FFFF_0000_0000, W_ZERO,
              1'b0, RES_UNTYPED},
            '{FAM_BAD_HI, 64'h0A00_0000_0000_0000, W_ZERO,
              64'h0A00_00FF_0000_0000, W_ZERO, 1'b1, RES_BAD_FAMILY},
            '{ipr_pkg::FAM_IPV6, W_ZERO, 64'h1, W_ONES, 64'hFFFF_FFFF_FFFF_FFFE,
              1'b0, RES_UNTYPED}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < N_DIRECTED; n++) begin
            send_pair(dir_rows[n].fam, {dir_rows[n].lu, dir_rows[n].ll},
                      {dir_rows[n].hu, dir_rows[n].hl}, dir_rows[n].typed,
                      dir_rows[n].res);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            // Some stretches run back to back with no gaps at all.
            if (n % 64 == 0) begin
                steady = ($urandom_range(0, 2) == 0);
            end
            make_random_pair(fam, lo, hi);
            send_pair(fam, lo, hi, 1'b0, RES_UNTYPED);
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_encodings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (pending_encodings.size() != 0) begin
            report_mismatch("encodings still pending at the end");
        end

        if (mismatch_count == 0) begin
            $display("ip_range_prefix_encoder_top verification clean");
        end else begin
            $display("ip_range_prefix_encoder_top verification failed");
        end
        $finish;
    end

endmodule
